### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, held off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, held off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/bdfl_pkg.sv
// ---------------------------------------------------------------------------
// bdfl_pkg
// Types and constants shared by the fold level blocks.
// ---------------------------------------------------------------------------
`default_nettype none

package bdfl_pkg;

   // Default sizes of the line counter and of the brace counters.
   localparam int LINE_BITS_DEF  = 16;
   localparam int DEPTH_BITS_DEF = 12;

   // Fold level width and its saturation value.
   localparam int             LEVEL_W   = 12;
   localparam logic [LEVEL_W-1:0] LEVEL_TOP = 12'hFFF;
   localparam logic [LEVEL_W-1:0] LEVEL_BASE_RST = 12'd1024;

   // Result queue sizing.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // Character codes.
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // Register map.
   localparam int CSR_ADDR_W = 4;
   typedef enum logic [1:0] {
      CSR_FOLD_MODE      = 2'd0,
      CSR_LEVEL_BASE     = 2'd1,
      CSR_OPERATOR_STYLE = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   // Folding modes.
   localparam logic MODE_BRACE   = 1'b0;
   localparam logic MODE_SECTION = 1'b1;

   typedef struct packed {
      logic [7:0] char_byte;
      logic [7:0] style_code;
      logic       buffer_end;
   } req_payload_type;

   typedef struct packed {
      logic [15:0]        line_number;
      logic [LEVEL_W-1:0] fold_level;
      logic               header_line;
      logic               blank_line;
      logic               final_record;
   } rsp_payload_type;

   typedef struct packed {
      logic               fold_mode;
      logic [LEVEL_W-1:0] level_base;
      logic [7:0]         operator_style;
   } cfg_type;

   // Records produced by one transaction: count is 0, 1 or 2.
   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type rec0;
      rsp_payload_type rec1;
   } trk_out_type;

endpackage

`default_nettype wire

### design/bdfl_line_track.sv
// ---------------------------------------------------------------------------
// bdfl_line_track
// Per-line brace and section tracking; forms up to two fold records per byte.
// ---------------------------------------------------------------------------
`default_nettype none

module bdfl_line_track
   import bdfl_pkg::*;
#(
   parameter int LINE_BITS  = LINE_BITS_DEF,
   parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            fire,
   input  wire req_payload_type item,
   input  wire cfg_type         cfg,
   output trk_out_type          trk
);

   localparam int SUM_W  = ((DEPTH_BITS > LEVEL_W) ? DEPTH_BITS : LEVEL_W) + 1;
   localparam int LINE_X = (LINE_BITS > 16) ? LINE_BITS : 16;

   // Tracker state.
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [LINE_BITS-1:0]  line_ff, line_in;
   logic [DEPTH_BITS-1:0] opens_ff, opens_in;
   logic [DEPTH_BITS-1:0] closes_ff, closes_in;
   logic                  nonempty_ff, nonempty_in;
   logic                  fvs_ff, fvs_in;
   logic                  fvb_ff, fvb_in;
   logic                  section_ff, section_in;

   // Line state after this byte is absorbed.
   logic [DEPTH_BITS-1:0] a_opens, a_closes;
   logic                  a_nonempty, a_fvs, a_fvb;
   // State after the line is closed.
   logic [DEPTH_BITS:0]   d_sum;
   logic [DEPTH_BITS-1:0] d_sat, d_post;
   logic [LINE_BITS-1:0]  l_post;
   logic                  s_post;
   logic                  is_nl, is_op;

   // Level of base plus a count, saturating at the top level.
   function automatic logic [LEVEL_W-1:0] level_sat(
      input logic [LEVEL_W-1:0]    base,
      input logic [DEPTH_BITS-1:0] net
   );
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(net);
      return (sum > SUM_W'(LEVEL_TOP)) ? LEVEL_TOP : sum[LEVEL_W-1:0];
   endfunction

   // Fold record of a line from its tracked state.
   function automatic rsp_payload_type build_rec(
      input cfg_type               c,
      input logic [DEPTH_BITS-1:0] depth,
      input logic [DEPTH_BITS-1:0] opens,
      input logic [DEPTH_BITS-1:0] closes,
      input logic                  nonempty,
      input logic                  fvb,
      input logic                  section,
      input logic [LINE_BITS-1:0]  line,
      input logic                  last
   );
      rsp_payload_type       r;
      logic [DEPTH_BITS-1:0] net;
      logic [LINE_X-1:0]     line_x;
      line_x         = LINE_X'(line);
      r.line_number  = line_x[15:0];
      r.final_record = last;
      if (c.fold_mode == MODE_SECTION) begin
         r.header_line = fvb;
         r.fold_level  = fvb ? c.level_base
                             : level_sat(c.level_base, DEPTH_BITS'(section));
         r.blank_line  = !fvb && !nonempty;
      end else begin
         net           = (depth > closes) ? depth - closes : '0;
         r.fold_level  = level_sat(c.level_base, net);
         r.header_line = (opens != '0);
         r.blank_line  = !nonempty && (opens == '0) && (closes == '0);
      end
      return r;
   endfunction

   // Absorb a non-newline byte into the current line.
   always_comb begin
      is_nl      = (item.char_byte == CH_LF);
      is_op      = (item.style_code == cfg.operator_style);
      a_opens    = opens_ff;
      a_closes   = closes_ff;
      a_nonempty = nonempty_ff;
      a_fvs      = fvs_ff;
      a_fvb      = fvb_ff;
      if (!is_nl) begin
         a_nonempty = 1'b1;
         if (!fvs_ff && item.char_byte != CH_SPACE && item.char_byte != CH_TAB) begin
            a_fvs = 1'b1;
            a_fvb = (item.char_byte == CH_LBRACK);
         end
         if (is_op && item.char_byte == CH_LBRACE) begin
            if (opens_ff != '1) begin
               a_opens = opens_ff + 1'b1;
            end
         end else if (is_op && item.char_byte == CH_RBRACE) begin
            if (opens_ff != '0) begin
               a_opens = opens_ff - 1'b1;
            end else if (closes_ff != '1) begin
               a_closes = closes_ff + 1'b1;
            end
         end
      end
   end

   // Carried state once the line is closed.
   always_comb begin
      d_sum  = {1'b0, depth_ff} + {1'b0, a_opens};
      d_sat  = d_sum[DEPTH_BITS] ? '1 : d_sum[DEPTH_BITS-1:0];
      d_post = (d_sat > a_closes) ? d_sat - a_closes : '0;
      l_post = (line_ff == '1) ? line_ff : line_ff + 1'b1;
      s_post = section_ff | a_fvb;
   end

   // Records for this transaction.
   always_comb begin
      trk.rec0 = build_rec(cfg, depth_ff, a_opens, a_closes, a_nonempty, a_fvb,
                           section_ff, line_ff, item.buffer_end & ~is_nl);
      trk.rec1 = build_rec(cfg, d_post, '0, '0, 1'b0, 1'b0, s_post, l_post, 1'b1);
      if (!fire) begin
         trk.count = 2'd0;
      end else if (is_nl) begin
         trk.count = item.buffer_end ? 2'd2 : 2'd1;
      end else begin
         trk.count = item.buffer_end ? 2'd1 : 2'd0;
      end
   end

   // Next state.
   always_comb begin
      depth_in    = depth_ff;
      line_in     = line_ff;
      section_in  = section_ff;
      opens_in    = opens_ff;
      closes_in   = closes_ff;
      nonempty_in = nonempty_ff;
      fvs_in      = fvs_ff;
      fvb_in      = fvb_ff;
      if (fire) begin
         if (item.buffer_end) begin
            depth_in    = '0;
            line_in     = '0;
            section_in  = 1'b0;
            opens_in    = '0;
            closes_in   = '0;
            nonempty_in = 1'b0;
            fvs_in      = 1'b0;
            fvb_in      = 1'b0;
         end else if (is_nl) begin
            depth_in    = d_post;
            line_in     = l_post;
            section_in  = s_post;
            opens_in    = '0;
            closes_in   = '0;
            nonempty_in = 1'b0;
            fvs_in      = 1'b0;
            fvb_in      = 1'b0;
         end else begin
            opens_in    = a_opens;
            closes_in   = a_closes;
            nonempty_in = a_nonempty;
            fvs_in      = a_fvs;
            fvb_in      = a_fvb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff    <= '0;
         line_ff     <= '0;
         opens_ff    <= '0;
         closes_ff   <= '0;
         nonempty_ff <= 1'b0;
         fvs_ff      <= 1'b0;
         fvb_ff      <= 1'b0;
         section_ff  <= 1'b0;
      end else begin
         depth_ff    <= depth_in;
         line_ff     <= line_in;
         opens_ff    <= opens_in;
         closes_ff   <= closes_in;
         nonempty_ff <= nonempty_in;
         fvs_ff      <= fvs_in;
         fvb_ff      <= fvb_in;
         section_ff  <= section_in;
      end
   end

endmodule

`default_nettype wire

### design/bdfl_out_fifo.sv
// ---------------------------------------------------------------------------
// bdfl_out_fifo
// Small result queue that takes up to two records a cycle and hands out one.
// ---------------------------------------------------------------------------
`default_nettype none

module bdfl_out_fifo
   import bdfl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire trk_out_type           trk,
   input  wire logic                  pop,
   output logic [FIFO_CNT_W-1:0]      count,
   output rsp_payload_type            head
);

   rsp_payload_type       entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic [FIFO_PTR_W-1:0] wr_next;

   // Pointer and fill count updates.
   always_comb begin
      wr_next   = wr_ptr_ff + 1'b1;
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(trk.count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      cnt_in    = cnt_ff + FIFO_CNT_W'(trk.count) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage: the first record lands at the write pointer, the second after it.
   always_ff @(posedge clock) begin
      if (trk.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= trk.rec0;
      end
      if (trk.count == 2'd2) begin
         entry_ff[wr_next] <= trk.rec1;
      end
   end

   assign count = cnt_ff;
   assign head  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### design/brace_depth_fold_levels.sv
// ---------------------------------------------------------------------------
// brace_depth_fold_levels
// Fold levels per text line from a stream of lexed bytes.
// ---------------------------------------------------------------------------
// The block takes one text byte per cycle and produces one fold record per
// line. A byte is held in the input register, where the line trackers
// update and form its records, and the records are then written into a
// four-entry result queue, from which rsp offers them in order. The queue
// bounds the rate: a byte is taken from the input register only while the
// queue holds at most two records, so with the result side never stalling
// the block sustains one byte per cycle, including a final newline that
// produces two records. Registers take effect for the next byte; there is
// no initialization pass after reset.
`default_nettype none

`include "assert_macros.svh"

module brace_depth_fold_levels
   import bdfl_pkg::*;
#(
   parameter int LINE_BITS  = LINE_BITS_DEF,
   parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_payload_type       req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   cfg_type               cfg_ff, cfg_in;
   logic                  in_vld_ff, in_vld_in;
   req_payload_type       in_pay_ff;
   logic                  req_accept, advance, pop;
   logic [FIFO_CNT_W-1:0] fifo_cnt;
   csr_index_type         csr_idx;
   trk_out_type           trk;

   // Register port: always ready, written on the access phase.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_idx)
            CSR_FOLD_MODE:      cfg_in.fold_mode      = csr_pwdata[0];
            CSR_LEVEL_BASE:     cfg_in.level_base     = csr_pwdata[LEVEL_W-1:0];
            CSR_OPERATOR_STYLE: cfg_in.operator_style = csr_pwdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_FOLD_MODE:      csr_prdata = {31'd0, cfg_ff.fold_mode};
         CSR_LEVEL_BASE:     csr_prdata = {{(32 - LEVEL_W){1'b0}}, cfg_ff.level_base};
         CSR_OPERATOR_STYLE: csr_prdata = {24'd0, cfg_ff.operator_style};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fold_mode      <= MODE_BRACE;
         cfg_ff.level_base     <= LEVEL_BASE_RST;
         cfg_ff.operator_style <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register: a byte moves on once the queue has room for two records.
   assign advance    = in_vld_ff && (fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign req_stall  = in_vld_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_pay_ff <= req_payload;
      end
   end

   // Line tracking and record forming.
   bdfl_line_track #(
      .LINE_BITS  (LINE_BITS),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_track (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (in_pay_ff),
      .cfg   (cfg_ff),
      .trk   (trk)
   );

   // Result queue feeding the rsp channel.
   assign rsp_valid = (fifo_cnt != '0);
   assign pop       = rsp_valid && !rsp_stall;

   bdfl_out_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .trk   (trk),
      .pop   (pop),
      .count (fifo_cnt),
      .head  (rsp_payload)
   );

   // The queue never overfills.
   `ASSERT_IMPLY(a_fifo_bound, clock, reset, 1'b1, fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH))
   // Fill count follows pushes and pops exactly.
   `ASSERT_NEXT(a_fifo_count, clock, reset, 1'b1, fifo_cnt == FIFO_CNT_W'($past(fifo_cnt) + FIFO_CNT_W'($past(trk.count)) - FIFO_CNT_W'($past(pop))))
   // A byte that ends the buffer always yields a record.
   `ASSERT_IMPLY(a_end_emits, clock, reset, advance && in_pay_ff.buffer_end, trk.count != 2'd0)
   // Of two records only the second closes the buffer.
   `ASSERT_IMPLY(a_pair_final, clock, reset, trk.count == 2'd2, trk.rec1.final_record && !trk.rec0.final_record)

endmodule

`default_nettype wire

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for brace_depth_fold_levels. A short directed table
// covers empty lines, brace matching, buffer ends, level saturation and
// section headers. Random text buffers then run under a series of register
// settings. Every record is checked field by field, against the table where
// a row gives it and else against a fold level predictor run in the bench.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import bdfl_pkg::*;

   localparam int DEPTH_MAX      = 2 ** DEPTH_BITS_DEF - 1;
   localparam int LINE_MAX       = 2 ** LINE_BITS_DEF - 1;
   localparam int PHASES         = 10;
   localparam int PHASE_BYTES    = 125;
   localparam int HOLD_PHASE     = 2;
   localparam int PAUSE_PHASE    = 5;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_CYCLES     = 20;
   localparam int REPORT_LINES   = 40;
   localparam longint LIMIT_NS   = 5_000_000;
   localparam logic [7:0] CH_LOWER_A = "a";

   typedef enum logic {
      ROW_BYTE,
      ROW_REG
   } row_kind_type;

   // One line of the directed table: a byte transaction or a register write.
   typedef struct packed {
      row_kind_type    kind;
      req_payload_type item;
      logic            checked;
      logic [1:0]      n_recs;
      rsp_payload_type rec_a;
      rsp_payload_type rec_b;
      csr_index_type   reg_idx;
      logic [31:0]     reg_value;
   } stim_row_type;

   // Ports of the block.
   logic            clock;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_psel = 1'b0;
   logic            csr_penable = 1'b0;
   logic            csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]     csr_pwdata = '0;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   // Register copies held by the predictor.
   logic               mode_m = MODE_BRACE;
   logic [LEVEL_W-1:0] base_m = LEVEL_BASE_RST;
   logic [7:0]         opstyle_m = 8'd0;

   // Line tracker state held by the predictor.
   logic [11:0] depth_m = '0;
   logic [15:0] line_m = '0;
   logic [11:0] opens_m = '0;
   logic [11:0] closes_m = '0;
   logic        nonempty_m = 1'b0;
   logic        vis_seen_m = 1'b0;
   logic        vis_bracket_m = 1'b0;
   logic        section_m = 1'b0;

   rsp_payload_type pending_records[$];

   bit sender_idle_on = 1'b0;
   bit receiver_idle_on = 1'b0;
   bit hold_request = 1'b0;

   int unsigned mismatch_count = 0;
   int unsigned n_bytes = 0;
   int unsigned n_records = 0;
   int unsigned n_headers = 0;
   int unsigned n_blanks = 0;
   int unsigned n_finals = 0;
   int unsigned n_reg_writes = 0;

   brace_depth_fold_levels i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Prints one line per mismatch, up to a cap, and counts all of them.
   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      if (mismatch_count < REPORT_LINES) begin
         $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   // Clears the per-line trackers after a record has been formed.
   function automatic void reset_line_trackers();
      opens_m = '0;
      closes_m = '0;
      nonempty_m = 1'b0;
      vis_seen_m = 1'b0;
      vis_bracket_m = 1'b0;
   endfunction

   // Forms the record of the line that is closing and carries the depth on.
   function automatic rsp_payload_type close_fold_line(logic is_final);
      rsp_payload_type rec;
      int unsigned lvl;
      int unsigned carried;
      logic hdr;
      logic blank;
      if (mode_m == MODE_SECTION) begin
         hdr = vis_bracket_m;
         lvl = hdr ? base_m : base_m + section_m;
         blank = !hdr && !nonempty_m;
      end else begin
         lvl = base_m + ((depth_m > closes_m) ? depth_m - closes_m : 0);
         hdr = (opens_m != 0);
         blank = !nonempty_m && opens_m == 0 && closes_m == 0;
      end
      rec.line_number  = line_m;
      rec.fold_level   = (lvl > LEVEL_TOP) ? LEVEL_TOP : LEVEL_W'(lvl);
      rec.header_line  = hdr;
      rec.blank_line   = blank;
      rec.final_record = is_final;

      // Opens add first and saturate, then closes take away down to zero.
      carried = depth_m + opens_m;
      if (carried > DEPTH_MAX) begin
         carried = DEPTH_MAX;
      end
      carried = (carried > closes_m) ? carried - closes_m : 0;
      depth_m = 12'(carried);
      if (vis_bracket_m) begin
         section_m = 1'b1;
      end
      if (line_m != LINE_MAX) begin
         line_m++;
      end
      reset_line_trackers();
      return rec;
   endfunction

   // Predicts the records caused by one byte transaction; returns their count.
   function automatic int fold_step(req_payload_type p, output rsp_payload_type a,
                                    output rsp_payload_type b);
      int n;
      n = 0;
      a = '0;
      b = '0;
      if (p.char_byte == CH_LF) begin
         a = close_fold_line(1'b0);
         n = 1;
         if (p.buffer_end) begin
            b = close_fold_line(1'b1);
            n = 2;
         end
      end else begin
         nonempty_m = 1'b1;
         if (!vis_seen_m && p.char_byte != CH_SPACE && p.char_byte != CH_TAB) begin
            vis_seen_m = 1'b1;
            vis_bracket_m = (p.char_byte == CH_LBRACK);
         end
         // Only operator-styled braces count; a close cancels an open first.
         if (p.style_code == opstyle_m) begin
            if (p.char_byte == CH_LBRACE) begin
               if (opens_m != DEPTH_MAX) begin
                  opens_m++;
               end
            end else if (p.char_byte == CH_RBRACE) begin
               if (opens_m != 0) begin
                  opens_m--;
               end else if (closes_m != DEPTH_MAX) begin
                  closes_m++;
               end
            end
         end
         if (p.buffer_end) begin
            a = close_fold_line(1'b1);
            n = 1;
         end
      end
      // A new buffer starts at line zero with no depth and no section.
      if (p.buffer_end) begin
         depth_m = '0;
         line_m = '0;
         section_m = 1'b0;
         reset_line_trackers();
      end
      return n;
   endfunction

   function automatic rsp_payload_type fold_rec(logic [15:0] line, logic [LEVEL_W-1:0] lvl,
                                                logic hdr, logic blank, logic fin);
      rsp_payload_type rec;
      rec.line_number  = line;
      rec.fold_level   = lvl;
      rec.header_line  = hdr;
      rec.blank_line   = blank;
      rec.final_record = fin;
      return rec;
   endfunction

   function automatic stim_row_type byte_row(logic [7:0] ch, logic [7:0] st, logic fin);
      stim_row_type r;
      r = '0;
      r.kind = ROW_BYTE;
      r.item.char_byte = ch;
      r.item.style_code = st;
      r.item.buffer_end = fin;
      return r;
   endfunction

   function automatic stim_row_type seen_row(logic [7:0] ch, logic [7:0] st, logic fin,
                                             logic [1:0] n, rsp_payload_type a,
                                             rsp_payload_type b);
      stim_row_type r;
      r = byte_row(ch, st, fin);
      r.checked = 1'b1;
      r.n_recs = n;
      r.rec_a = a;
      r.rec_b = b;
      return r;
   endfunction

   function automatic stim_row_type reg_row(csr_index_type idx, logic [31:0] value);
      stim_row_type r;
      r = '0;
      r.kind = ROW_REG;
      r.reg_idx = idx;
      r.reg_value = value;
      return r;
   endfunction

   function automatic int idle_draw(bit enabled);
      return enabled ? $urandom_range(0, 11) : 0;
   endfunction

   // Text-like bytes: braces, line ends, brackets, blanks, letters and noise.
   function automatic logic [7:0] random_text_byte();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return CH_LBRACE;
      if (r < 28) return CH_RBRACE;
      if (r < 40) return CH_LF;
      if (r < 46) return CH_LBRACK;
      if (r < 54) return CH_SPACE;
      if (r < 58) return CH_TAB;
      if (r < 90) return CH_LOWER_A + 8'($urandom_range(0, 25));
      return 8'($urandom_range(0, 255));
   endfunction

   // Offers one byte transaction, then queues the records it should cause.
   task automatic send_row(stim_row_type r);
      rsp_payload_type a;
      rsp_payload_type b;
      int n;
      int gap;
      gap = idle_draw(sender_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r.item;
      do @(posedge clock); while (req_stall);
      n = fold_step(r.item, a, b);
      if (r.checked) begin
         n = r.n_recs;
         a = r.rec_a;
         b = r.rec_b;
      end
      if (n > 0) pending_records.push_back(a);
      if (n > 1) pending_records.push_back(b);
      n_bytes++;
   endtask

   // Waits until every record has come back and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_records.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register, mirrors it in the predictor and reads it back.
   task automatic write_register(csr_index_type idx, logic [31:0] value);
      logic [31:0] held;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         CSR_FOLD_MODE: begin
            mode_m = value[0];
            held = {31'd0, value[0]};
         end
         CSR_LEVEL_BASE: begin
            base_m = value[LEVEL_W-1:0];
            held = {20'd0, value[LEVEL_W-1:0]};
         end
         CSR_OPERATOR_STYLE: begin
            opstyle_m = value[7:0];
            held = {24'd0, value[7:0]};
         end
         default: begin
            held = '0;
         end
      endcase
      n_reg_writes++;

      // Same address, now as a read.
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== held) begin
         report_mismatch($sformatf("register %s read back", idx.name()), csr_prdata, held);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Result side: random stalls per record, plus one long hold-off on request.
   initial begin
      int n;
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            n = idle_draw(receiver_idle_on);
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Each accepted record is compared with the oldest expected one.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_records++;
         n_headers += rsp_payload.header_line;
         n_blanks += rsp_payload.blank_line;
         n_finals += rsp_payload.final_record;
         if (pending_records.size() == 0) begin
            report_mismatch("record with none expected, line", rsp_payload.line_number, 0);
         end else begin
            want = pending_records.pop_front();
            if (rsp_payload.line_number !== want.line_number)
               report_mismatch("line_number", rsp_payload.line_number, want.line_number);
            if (rsp_payload.fold_level !== want.fold_level)
               report_mismatch("fold_level", rsp_payload.fold_level, want.fold_level);
            if (rsp_payload.header_line !== want.header_line)
               report_mismatch("header_line", rsp_payload.header_line, want.header_line);
            if (rsp_payload.blank_line !== want.blank_line)
               report_mismatch("blank_line", rsp_payload.blank_line, want.blank_line);
            if (rsp_payload.final_record !== want.final_record)
               report_mismatch("final_record", rsp_payload.final_record, want.final_record);
         end
      end
   end

   // Main sequence: reset, directed table, then random phases.
   initial begin
      stim_row_type directed_rows[$];
      stim_row_type row;
      logic [11:0] base_pick;
      logic [7:0]  style_pick;
      logic [7:0]  ch;
      logic [7:0]  st;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: brace mode, base 1024, operator style 0.
      directed_rows.push_back(seen_row(CH_LF, 8'd0, 1'b0, 2'd1,
                                       fold_rec(0, 1024, 0, 1, 0), '0));
      directed_rows.push_back(seen_row(CH_LBRACE, 8'd0, 1'b0, 2'd0, '0, '0));
      directed_rows.push_back(seen_row(CH_LF, 8'd0, 1'b0, 2'd1,
                                       fold_rec(1, 1024, 1, 0, 0), '0));
      directed_rows.push_back(seen_row(CH_RBRACE, 8'd0, 1'b0, 2'd0, '0, '0));
      directed_rows.push_back(seen_row(CH_LF, 8'd0, 1'b0, 2'd1,
                                       fold_rec(2, 1024, 0, 0, 0), '0));
      // A brace in another style does not count; close then open on one line.
      directed_rows.push_back(byte_row(CH_LBRACE, 8'hFF, 1'b0));
      directed_rows.push_back(byte_row(CH_RBRACE, 8'd0, 1'b0));
      directed_rows.push_back(byte_row(CH_LBRACE, 8'd0, 1'b0));
      // A newline that ends the buffer gives its line and an empty final line.
      directed_rows.push_back(seen_row(CH_LF, 8'd0, 1'b1, 2'd2,
                                       fold_rec(3, 1024, 1, 0, 0),
                                       fold_rec(4, 1024, 0, 1, 1)));
      directed_rows.push_back(seen_row(8'hFF, 8'hFF, 1'b1, 2'd1,
                                       fold_rec(0, 1024, 0, 0, 1), '0));
      // An open cancelled on its own line, then a close below zero depth.
      directed_rows.push_back(byte_row(CH_LBRACE, 8'd0, 1'b0));
      directed_rows.push_back(byte_row(CH_RBRACE, 8'd0, 1'b0));
      directed_rows.push_back(byte_row(CH_LF, 8'd0, 1'b0));
      directed_rows.push_back(byte_row(CH_RBRACE, 8'd0, 1'b0));
      directed_rows.push_back(byte_row(CH_LF, 8'd0, 1'b0));
      // Top base and top style: levels saturate.
      directed_rows.push_back(reg_row(CSR_LEVEL_BASE, 32'd4095));
      directed_rows.push_back(reg_row(CSR_OPERATOR_STYLE, 32'd255));
      directed_rows.push_back(byte_row(CH_LBRACE, 8'd255, 1'b0));
      directed_rows.push_back(byte_row(CH_LF, 8'd0, 1'b0));
      directed_rows.push_back(seen_row(8'h00, 8'h00, 1'b1, 2'd1,
                                       fold_rec(3, LEVEL_TOP, 0, 0, 1), '0));
      // Section mode at base zero: a header after leading blanks.
      directed_rows.push_back(reg_row(CSR_FOLD_MODE, 32'(MODE_SECTION)));
      directed_rows.push_back(reg_row(CSR_LEVEL_BASE, 32'd0));
      directed_rows.push_back(byte_row(CH_SPACE, 8'd0, 1'b0));
      directed_rows.push_back(byte_row(CH_TAB, 8'd0, 1'b0));
      directed_rows.push_back(byte_row(CH_LBRACK, 8'd0, 1'b0));
      directed_rows.push_back(seen_row(CH_LF, 8'd0, 1'b0, 2'd1,
                                       fold_rec(0, 0, 1, 0, 0), '0));
      directed_rows.push_back(byte_row(CH_LOWER_A, 8'd0, 1'b0));
      directed_rows.push_back(byte_row(CH_LF, 8'd0, 1'b0));
      directed_rows.push_back(byte_row(CH_LF, 8'd0, 1'b1));

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_REG) begin
            wait_idle();
            write_register(row.reg_idx, row.reg_value);
         end else begin
            send_row(row);
         end
      end

      // Random text under a new register setting per phase.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case ($urandom_range(0, 3))
            0: base_pick = 12'd0;
            1: base_pick = LEVEL_TOP;
            2: base_pick = LEVEL_BASE_RST;
            default: base_pick = 12'($urandom_range(0, 4095));
         endcase
         case ($urandom_range(0, 3))
            0: style_pick = 8'd0;
            1: style_pick = 8'd255;
            default: style_pick = 8'($urandom_range(0, 255));
         endcase
         write_register(CSR_FOLD_MODE, 32'($urandom_range(0, 1)));
         write_register(CSR_LEVEL_BASE, 32'(base_pick));
         write_register(CSR_OPERATOR_STYLE, 32'(style_pick));

         // The first phase runs without idling on either side.
         sender_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         receiver_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         if (phase == HOLD_PHASE) begin
            sender_idle_on = 1'b0;
            hold_request = 1'b1;
         end

         for (int k = 0; k < PHASE_BYTES; k++) begin
            if (phase == PAUSE_PHASE && k == PHASE_BYTES / 2) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (pending_records.size() != 0);
            end
            ch = random_text_byte();
            st = ($urandom_range(0, 9) < 8) ? opstyle_m : 8'($urandom_range(0, 255));
            send_row(byte_row(ch, st, $urandom_range(0, 24) == 0));
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_records.size() != 0);
      repeat (END_CYCLES) @(posedge clock);

      $display("covered %0d bytes and %0d fold records (%0d header, %0d blank, %0d final)",
               n_bytes, n_records, n_headers, n_blanks, n_finals);
      $display("%0d register writes were read back across both fold modes", n_reg_writes);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Ends a run that hangs.
   initial begin
      #(LIMIT_NS);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/bdfl_pkg.sv
design/bdfl_line_track.sv
design/bdfl_out_fifo.sv
design/brace_depth_fold_levels.sv
tb/testbench.sv
